// ===== rtl/core/f32sc_pkg.sv =====
// Package for the Fletcher-32 signed block checksum.
// Holds the sum type, reset constants and the fold function; no dependencies.
`default_nettype none

package f32sc_pkg;

    localparam int          DEF_BLOCK_LEN = 360;
    localparam logic [31:0] SUM_INIT      = 32'h0000_ffff;

    typedef struct packed {
        logic [31:0] sum1;
        logic [31:0] sum2;
    } t_sums;

    // low half plus sign-preserving high half
    function automatic logic [31:0] fold16(input logic [31:0] v);
        fold16 = {16'h0000, v[15:0]} + {{16{v[31]}}, v[31:16]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/f32sc_final.sv =====
// Final fold and result register of the checksum.
// Takes once-folded sums of a finished message; uses f32sc_pkg.
`default_nettype none

module f32sc_final (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire f32sc_pkg::t_sums i_sums,
    output logic                  o_ready,
    output logic                  o_m_tvalid,
    output logic [31:0]           o_m_tdata,
    input  wire logic             i_m_tready
);
    import f32sc_pkg::*;

    logic        r_p_valid;
    t_sums       r_p_sums;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        out_adv;
    logic [31:0] fin1;
    logic [31:0] fin2;
    logic [31:0] n_out_data;

    assign out_adv = !r_out_valid || i_m_tready;
    assign o_ready = !r_p_valid || out_adv;

    assign fin1       = fold16(r_p_sums.sum1);
    assign fin2       = fold16(r_p_sums.sum2);
    assign n_out_data = {fin2[15:0], 16'h0000} | fin1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_p_valid <= i_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_p_sums <= i_sums;
        end
        if (out_adv && r_p_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// ===== rtl/core/fletcher32_signed_block_checksum_top.sv =====
// Top level of the Fletcher-32 signed block checksum.
// Holds the running sums and block counter; uses f32sc_pkg and f32sc_final.
`default_nettype none

// Takes one signed 16-bit word per cycle while s_tready is high, and emits one
// 32-bit checksum word per message; the final sums of a message pass through
// the input register and the result register of f32sc_final. Both sums start
// at 0xffff, fold every BLOCK_LEN words and at the end of a message, and return
// to 0xffff after each message. A stalled result holds back new words only
// when a second finished message is already waiting behind it.
module fletcher32_signed_block_checksum_top #(
    parameter int BLOCK_LEN = f32sc_pkg::DEF_BLOCK_LEN
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] word
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] checksum
);
    import f32sc_pkg::*;

    localparam int CW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN + 1) : 1;

    logic [31:0] r_sum1;
    logic [31:0] r_sum2;
    logic [CW-1:0] r_cnt;
    logic [31:0] n_sum1;
    logic [31:0] n_sum2;
    logic [CW-1:0] n_cnt;

    logic [31:0]   w32;
    logic [31:0]   add1;
    logic [31:0]   add2;
    logic [CW-1:0] cnt_inc;
    logic          blk_end;
    logic          fold_now;
    t_sums         folded;
    logic          accept;
    logic          fin_ready;

    assign accept  = s_tvalid && s_tready;
    assign w32     = {{16{s_tdata[15]}}, s_tdata};
    assign add1    = r_sum1 + w32;
    assign add2    = r_sum2 + r_sum1 + w32;
    assign cnt_inc = r_cnt + CW'(1);
    assign blk_end = cnt_inc >= CW'(BLOCK_LEN);
    assign fold_now = blk_end || s_tlast;

    always_comb begin
        folded.sum1 = fold_now ? fold16(add1) : add1;
        folded.sum2 = fold_now ? fold16(add2) : add2;
        n_sum1 = r_sum1;
        n_sum2 = r_sum2;
        n_cnt  = r_cnt;
        if (accept) begin
            if (s_tlast) begin
                n_sum1 = SUM_INIT;
                n_sum2 = SUM_INIT;
                n_cnt  = '0;
            end else begin
                n_sum1 = folded.sum1;
                n_sum2 = folded.sum2;
                n_cnt  = blk_end ? '0 : cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum1 <= SUM_INIT;
            r_sum2 <= SUM_INIT;
            r_cnt  <= '0;
        end else begin
            r_sum1 <= n_sum1;
            r_sum2 <= n_sum2;
            r_cnt  <= n_cnt;
        end
    end

    f32sc_final u_final (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (accept && s_tlast),
        .i_sums     (folded),
        .o_ready    (fin_ready),
        .o_m_tvalid (m_tvalid),
        .o_m_tdata  (m_tdata),
        .i_m_tready (m_tready)
    );

    assign s_tready = fin_ready;

endmodule

`default_nettype wire
